@@ rtl/core/ssr_pkg.sv @@
// Shared types, widths and constants for the smoothed setpoint ramp.
// Holds the sequencer state type, the phase codes and the saturation helper.
// No dependencies.
package ssr_pkg;

  localparam int ValW  = 25;
  localparam int StepW = 24;
  localparam int FacW  = 17;
  localparam int WinW  = 24;
  localparam int DistW = 26;
  localparam int MulAW = 25;
  localparam int MulBW = 17;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = 48;
  localparam int SumW  = 34;

  localparam logic [FacW-1:0] ONE_Q16 = 17'h10000;

  localparam logic CFG_SMOOTH = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_FS      = 3'd0;
  localparam phase_t PH_KEEP    = 3'd1;
  localparam phase_t PH_FSD_LO  = 3'd2;
  localparam phase_t PH_FSD_HI  = 3'd3;
  localparam phase_t PH_LIM_LO  = 3'd4;
  localparam phase_t PH_LIM_HI  = 3'd5;
  localparam phase_t PH_LIM_ACC = 3'd6;
  localparam phase_t PH_COMMIT  = 3'd7;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic   load;
    logic   run;
    phase_t phase;
    logic   commit;
  } ssr_ctl_t;

  function automatic logic signed [ValW-1:0] sat25(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = 34'sd16777215;
    lo = -34'sd16777216;
    if (v > hi) begin
      sat25 = 25'sd16777215;
    end else if (v < lo) begin
      sat25 = -25'sd16777216;
    end else begin
      sat25 = v[ValW-1:0];
    end
  endfunction

endpackage

@@ rtl/core/ssr_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Depends on ssr_pkg for operand and product widths.
module ssr_mul (
  input  logic                       clk,
  input  logic [ssr_pkg::MulAW-1:0]  a,
  input  logic [ssr_pkg::MulBW-1:0]  b,
  output logic [ssr_pkg::ProdW-1:0]  p_r
);

  logic [ssr_pkg::ProdW-1:0] p_nxt;

  assign p_nxt = ssr_pkg::ProdW'(a) * ssr_pkg::ProdW'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

@@ rtl/core/ssr_seq.sv @@
// Sequencer stepping the shared multiplier through the eight phases of a word.
// Depends on ssr_pkg for the state type, phase codes and control struct.
module ssr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              slot_free,
  output logic              ready,
  output ssr_pkg::ssr_ctl_t ctl
);

  ssr_pkg::state_t state_r;
  ssr_pkg::state_t state_nxt;
  ssr_pkg::phase_t phase_r;
  ssr_pkg::phase_t phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ssr_pkg::ST_IDLE: begin
        phase_nxt = ssr_pkg::PH_FS;
        if (in_valid) begin
          state_nxt = ssr_pkg::ST_RUN;
        end
      end
      ssr_pkg::ST_RUN: begin
        if (phase_r != ssr_pkg::PH_COMMIT) begin
          phase_nxt = phase_r + 3'd1;
        end else if (slot_free) begin
          state_nxt = ssr_pkg::ST_IDLE;
          phase_nxt = ssr_pkg::PH_FS;
        end
      end
      default: begin
        state_nxt = ssr_pkg::ST_IDLE;
        phase_nxt = ssr_pkg::PH_FS;
      end
    endcase
  end

  always_comb begin
    ready      = 1'b0;
    ctl.load   = 1'b0;
    ctl.run    = 1'b0;
    ctl.phase  = phase_r;
    ctl.commit = 1'b0;
    case (state_r)
      ssr_pkg::ST_IDLE: begin
        ready    = 1'b1;
        ctl.load = in_valid;
      end
      ssr_pkg::ST_RUN: begin
        ctl.run    = 1'b1;
        ctl.commit = (phase_r == ssr_pkg::PH_COMMIT) && slot_free;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssr_pkg::ST_IDLE;
      phase_r <= ssr_pkg::PH_FS;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ rtl/core/smoothed_setpoint_ramp.sv @@
// A word accepted in idle runs through the eight sequencer phases FS, KEEP, FSD_LO, FSD_HI,
// LIM_LO, LIM_HI, LIM_ACC and COMMIT (six multiplier passes, one accumulate, one commit).
// COMMIT waits for a free output; the sequencer then returns to idle to accept the next word.
// The input is not ready while a word is at work; a finished result waits in the output register.
// Reset (synchronous, rst_n low): value and ramped step clear to zero, the factor and the
// window return to 1.0, the output register empties. Depends on ssr_pkg, ssr_seq, ssr_mul.
module smoothed_setpoint_ramp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // target[24:0], step_size[48:25], zero[55:49]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // new_value[24:0], new_ramped_step[49:25], at_target[50]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  ssr_pkg::ssr_ctl_t ctl;
  logic              slot_free;

  logic [ssr_pkg::FacW-1:0]         smoothing_factor_r;
  logic [ssr_pkg::WinW-1:0]         center_window_r;
  logic signed [ssr_pkg::ValW-1:0]  current_value_r;
  logic signed [ssr_pkg::ValW-1:0]  ramped_step_reg_r;

  logic signed [ssr_pkg::ValW-1:0]  target_r;
  logic [ssr_pkg::StepW-1:0]        step_r;
  logic signed [ssr_pkg::DistW-1:0] d_r;
  logic [ssr_pkg::DistW-1:0]        ad_r;
  logic                             inwin_r;
  logic [ssr_pkg::StepW-1:0]        fs_r;
  logic [ssr_pkg::DistW-1:0]        keep_mag_r;
  logic [ssr_pkg::AccW-1:0]         acc_r;
  logic signed [ssr_pkg::ValW-1:0]  ramped_r;

  logic                             out_tvalid_r;
  logic signed [ssr_pkg::ValW-1:0]  out_value_r;
  logic signed [ssr_pkg::ValW-1:0]  out_ramped_r;
  logic                             out_at_r;

  logic signed [ssr_pkg::ValW-1:0]  in_target;
  logic [ssr_pkg::StepW-1:0]        in_step;
  logic signed [ssr_pkg::DistW-1:0] d_nxt;
  logic [ssr_pkg::DistW-1:0]        ad_nxt;
  logic [ssr_pkg::FacW-1:0]         f_eff;
  logic [ssr_pkg::ValW-1:0]         rs_mag;

  logic [ssr_pkg::MulAW-1:0]        mul_a;
  logic [ssr_pkg::MulBW-1:0]        mul_b;
  logic [ssr_pkg::ProdW-1:0]        p_r;

  logic                             d_neg;
  logic                             d_zero;
  logic signed [ssr_pkg::SumW-1:0]  keep_s;
  logic signed [ssr_pkg::SumW-1:0]  term_mag;
  logic signed [ssr_pkg::SumW-1:0]  term_s;
  logic signed [ssr_pkg::ValW-1:0]  ramped_nxt;

  logic [ssr_pkg::ValW-1:0]         ar;
  logic [30:0]                      lim;
  logic [ssr_pkg::ValW-1:0]         m;
  logic                             snap;
  logic signed [ssr_pkg::SumW-1:0]  move_s;
  logic signed [ssr_pkg::ValW-1:0]  value_nxt;

  ssr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .slot_free (slot_free),
    .ready     (in_tready),
    .ctl       (ctl)
  );

  ssr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  assign slot_free = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothing_factor_r <= ssr_pkg::ONE_Q16;
      center_window_r    <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssr_pkg::CFG_SMOOTH: smoothing_factor_r <= cfg_data[ssr_pkg::FacW-1:0];
        ssr_pkg::CFG_WINDOW: center_window_r    <= cfg_data;
        default: begin
          center_window_r <= center_window_r;
        end
      endcase
    end
  end

  // distance and window test at accept
  assign in_target = in_tdata[24:0];
  assign in_step   = in_tdata[48:25];
  assign d_nxt     = ssr_pkg::DistW'(in_target) - ssr_pkg::DistW'(current_value_r);
  assign ad_nxt    = d_nxt[ssr_pkg::DistW-1] ? ssr_pkg::DistW'(-d_nxt) : ssr_pkg::DistW'(d_nxt);
  assign f_eff     = (smoothing_factor_r > ssr_pkg::ONE_Q16) ? ssr_pkg::ONE_Q16
                                                             : smoothing_factor_r;
  assign rs_mag    = ramped_step_reg_r[ssr_pkg::ValW-1] ? ssr_pkg::ValW'(-ramped_step_reg_r)
                                                        : ssr_pkg::ValW'(ramped_step_reg_r);

  always_comb begin
    case (ctl.phase)
      ssr_pkg::PH_FS: begin
        mul_a = ssr_pkg::MulAW'(step_r);
        mul_b = f_eff;
      end
      ssr_pkg::PH_KEEP: begin
        mul_a = rs_mag;
        mul_b = ssr_pkg::ONE_Q16 - f_eff;
      end
      ssr_pkg::PH_FSD_LO: begin
        mul_a = ssr_pkg::MulAW'(fs_r);
        mul_b = ssr_pkg::MulBW'(ad_r[11:0]);
      end
      ssr_pkg::PH_FSD_HI: begin
        mul_a = ssr_pkg::MulAW'(fs_r);
        mul_b = ssr_pkg::MulBW'(ad_r[23:12]);
      end
      ssr_pkg::PH_LIM_LO: begin
        mul_a = ssr_pkg::MulAW'(step_r);
        mul_b = ssr_pkg::MulBW'(ad_r[11:0]);
      end
      default: begin
        mul_a = ssr_pkg::MulAW'(step_r);
        mul_b = ssr_pkg::MulBW'(ad_r[23:12]);
      end
    endcase
  end

  // ramped step from the blend terms
  assign d_neg    = d_r[ssr_pkg::DistW-1];
  assign d_zero   = (d_r == '0);
  assign keep_s   = ramped_step_reg_r[ssr_pkg::ValW-1]
                    ? -$signed({8'b0, keep_mag_r}) : $signed({8'b0, keep_mag_r});
  assign term_mag = inwin_r ? $signed({3'b0, acc_r[47:17]}) : $signed({10'b0, fs_r});
  assign term_s   = d_neg ? -term_mag : (d_zero ? '0 : term_mag);
  assign ramped_nxt = ssr_pkg::sat25(term_s + keep_s);

  // move limit, snap and new value
  assign ar     = ramped_r[ssr_pkg::ValW-1] ? ssr_pkg::ValW'(-ramped_r)
                                            : ssr_pkg::ValW'(ramped_r);
  assign lim    = acc_r[47:17];
  assign m      = ({6'b0, ar} < lim) ? ar : lim[ssr_pkg::ValW-1:0];
  assign snap   = inwin_r && (ad_r < {1'b0, m});

  always_comb begin
    if (inwin_r) begin
      if (d_neg) begin
        move_s = -$signed({9'b0, m});
      end else if (d_zero) begin
        move_s = '0;
      end else begin
        move_s = $signed({9'b0, m});
      end
    end else begin
      move_s = ssr_pkg::SumW'(ramped_r);
    end
  end

  assign value_nxt = snap ? target_r
                          : ssr_pkg::sat25(ssr_pkg::SumW'(current_value_r) + move_s);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      target_r <= in_target;
      step_r   <= in_step;
      d_r      <= d_nxt;
      ad_r     <= ad_nxt;
      inwin_r  <= ad_nxt < ssr_pkg::DistW'(center_window_r);
    end
    if (ctl.run) begin
      case (ctl.phase)
        ssr_pkg::PH_KEEP:    fs_r       <= p_r[39:16];
        ssr_pkg::PH_FSD_LO:  keep_mag_r <= p_r[41:16];
        ssr_pkg::PH_FSD_HI:  acc_r      <= {6'b0, p_r};
        ssr_pkg::PH_LIM_LO:  acc_r      <= acc_r + {p_r[35:0], 12'b0};
        ssr_pkg::PH_LIM_HI: begin
          ramped_r <= ramped_nxt;
          acc_r    <= {6'b0, p_r};
        end
        ssr_pkg::PH_LIM_ACC: acc_r      <= acc_r + {p_r[35:0], 12'b0};
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_value_r   <= '0;
      ramped_step_reg_r <= '0;
      out_tvalid_r      <= 1'b0;
    end else if (ctl.commit) begin
      current_value_r   <= value_nxt;
      ramped_step_reg_r <= ramped_r;
      out_tvalid_r      <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_value_r  <= value_nxt;
      out_ramped_r <= ramped_r;
      out_at_r     <= snap;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_at_r, out_ramped_r, out_value_r};

endmodule
